// ===== src/assert_macros.svh =====
// Assertion macros shared by the deque RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, checked only while out of reset.
`define CDQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property, checked during reset as well.
`define CDQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDQ_ASSERT(label, clk, rst_n, prop, msg)
`define CDQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== src/cdq_pkg.sv =====
// Types, codes and index helpers for the circular deque.
// No dependencies; imported by circular_deque_top, cdq_checker and tb_top.
package cdq_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CFG_W  = 7;
    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;

    // Action codes of an input item.
    localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PEEK_FRONT = 3'd4;
    localparam logic [ACT_W-1:0] ACT_PEEK_REAR  = 3'd5;

    // Status codes of a result item.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(DEPTH);

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [STAT_W-1:0]        status;
        logic [CNT_W-1:0]         count;
    } t_out_item;

    // Step an index forward, wrapping at the capacity in use.
    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] inc;
        inc = CNT_W'(i) + CNT_W'(1);
        return (inc >= cap) ? '0 : IDX_W'(inc);
    endfunction

    // Step an index back, wrapping to capacity - 1.
    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] top;
        top = cap - CNT_W'(1);
        return (i == '0 || CNT_W'(i) > cap) ? IDX_W'(top) : i - IDX_W'(1);
    endfunction

endpackage

// ===== src/cdq_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
// Generic; no package dependencies.
module cdq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/circular_deque_top.sv =====
// Circular deque top level: index and count control, result pipeline.
// Depends on cdq_pkg, cdq_ram and assert_macros.svh.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  in      | input     | i_in_valid/o_in_stall   | i_in_item (action, value)
//  out     | output    | o_out_valid/i_out_stall | o_out_item (data, status, count)
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (capacity in use)
//
// One item per cycle is accepted unless the input is stalled; its result passes
// through the RAM stage (registered RAM read) and then the output register.
// Indices and count update in the accept cycle, so back-to-back items see them.
// A stalled output backs up into the RAM stage and then stalls the input.
// Synchronous reset empties the deque and sets the capacity to 64; RAM contents
// are not cleared and need no clearing pass.
`include "assert_macros.svh"

module circular_deque_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cdq_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cdq_pkg::t_out_item o_out_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [cdq_pkg::CFG_W-1:0] i_cfg_data
);
    import cdq_pkg::*;

    logic [CFG_W-1:0]  r_cap;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;

    logic              r_s1_valid;
    logic              r_s1_use_mem, n_s1_use_mem;
    logic signed [DATA_W-1:0] r_s1_data, n_s1_data;
    logic [STAT_W-1:0] r_s1_status, n_s1_status;
    logic [CNT_W-1:0]  r_s1_count;

    logic              r_out_valid;
    t_out_item         r_out;

    logic [CNT_W-1:0]  w_cap;
    logic              w_in_acc;
    logic              w_s1_move;
    logic              w_we;
    logic              w_re;
    logic [IDX_W-1:0]  w_waddr;
    logic [IDX_W-1:0]  w_raddr;
    logic [DATA_W-1:0] w_rdata;
    logic              w_is_push;

    // Configuration register; the user must write it only while the block is idle, which the block does not enforce.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    // Effective capacity: zero acts as one, values above the depth act as the depth.
    always_comb begin
        if (r_cap == '0) begin
            w_cap = CNT_W'(1);
        end else if (r_cap > CFG_W'(DEPTH)) begin
            w_cap = CNT_W'(DEPTH);
        end else begin
            w_cap = CNT_W'(r_cap);
        end
    end

    // Handshake: the RAM stage advances when the output register is free or drains.
    assign w_s1_move  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_s1_move;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_is_push  = (i_in_item.action == ACT_PUSH_REAR) ||
                        (i_in_item.action == ACT_PUSH_FRONT);

    // Index, count and RAM access decisions for the item being accepted.
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_s1_use_mem = 1'b0;
        n_s1_data    = '0;
        n_s1_status  = ST_OK;
        w_we         = 1'b0;
        w_re         = 1'b0;
        w_waddr      = '0;
        w_raddr      = r_head;
        unique case (i_in_item.action)
            ACT_PUSH_REAR, ACT_PUSH_FRONT: begin
                n_s1_data = i_in_item.value;
                if (r_count >= w_cap) begin
                    n_s1_status = ST_FULL;
                end else begin
                    w_we    = w_in_acc;
                    n_count = r_count + CNT_W'(1);
                    if (r_count == '0) begin
                        n_head  = '0;
                        n_tail  = '0;
                        w_waddr = '0;
                    end else if (i_in_item.action == ACT_PUSH_REAR) begin
                        n_tail  = idx_next(r_tail, w_cap);
                        w_waddr = n_tail;
                    end else begin
                        n_head  = idx_prev(r_head, w_cap);
                        w_waddr = n_head;
                    end
                end
            end
            ACT_POP_FRONT, ACT_POP_REAR, ACT_PEEK_FRONT, ACT_PEEK_REAR: begin
                if (r_count == '0) begin
                    n_s1_data   = '1;
                    n_s1_status = ST_EMPTY;
                end else begin
                    n_s1_use_mem = 1'b1;
                    w_re         = w_in_acc;
                    if (i_in_item.action == ACT_POP_FRONT ||
                        i_in_item.action == ACT_PEEK_FRONT) begin
                        w_raddr = r_head;
                    end else begin
                        w_raddr = r_tail;
                    end
                    if (i_in_item.action == ACT_POP_FRONT) begin
                        n_count = r_count - CNT_W'(1);
                        if (r_count > CNT_W'(1)) begin
                            n_head = idx_next(r_head, w_cap);
                        end
                    end else if (i_in_item.action == ACT_POP_REAR) begin
                        n_count = r_count - CNT_W'(1);
                        if (r_count > CNT_W'(1)) begin
                            n_tail = idx_prev(r_tail, w_cap);
                        end
                    end
                end
            end
            default: begin
                // Undefined actions change nothing and report zero data.
                n_s1_data = '0;
            end
        endcase
    end

    // Deque control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (w_in_acc) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Ring store.
    cdq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in_item.value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // RAM stage: result fields that do not come from the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_use_mem <= n_s1_use_mem;
            r_s1_data    <= n_s1_data;
            r_s1_status  <= n_s1_status;
            r_s1_count   <= n_count;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out.data   <= r_s1_use_mem ? w_rdata : r_s1_data;
            r_out.status <= r_s1_status;
            r_out.count  <= r_s1_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Checks on the control logic.
    `CDQ_ASSERT(a_count_in_range, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "count above depth")
    `CDQ_ASSERT(a_stall_needs_s1, i_clk, i_rst_n, o_in_stall |-> r_s1_valid, "stall without pending item")
    `CDQ_ASSERT(a_s1_held, i_clk, i_rst_n, (r_s1_valid && !w_s1_move) |=> r_s1_valid, "pending item lost")
    `CDQ_ASSERT(a_empty_read_keeps, i_clk, i_rst_n, (w_in_acc && r_count == '0 && !w_is_push) |=> r_count == '0, "read on empty changed count")
    `CDQ_ASSERT_ALWAYS(a_no_write_and_read, i_clk, !(w_we && w_re), "RAM read and write in one cycle")

endmodule

// ===== dv/cdq_checker.sv =====
// Result checker for circular_deque_top: tracks deque state from accepted items and
// compares every accepted result with the oldest awaited one.
// Depends on cdq_pkg for the item types, codes and sizes.
module cdq_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  cdq_pkg::t_in_item         i_in_item,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  cdq_pkg::t_out_item        i_out_item,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [cdq_pkg::CFG_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending,
    output logic                      o_front_known,
    output logic                      o_rear_known
);
    import cdq_pkg::*;

    // Shadow of the deque: ring contents, which entries hold a word, indices and fill.
    logic signed [DATA_W-1:0] ring_shadow [DEPTH];
    bit                       ring_written [DEPTH];
    logic [IDX_W-1:0]         front_idx;
    logic [IDX_W-1:0]         rear_idx;
    logic [CNT_W-1:0]         stored;
    logic [CFG_W-1:0]         cap_reg;
    t_out_item                awaited_results [$];
    t_out_item                want;
    int                       mismatches;

    // Capacity actually in force: zero acts as one, anything above the ring as the ring.
    function automatic int ring_span();
        if (cap_reg == '0) begin
            return 1;
        end
        if (cap_reg > DEPTH) begin
            return DEPTH;
        end
        return int'(cap_reg);
    endfunction

    function automatic logic [IDX_W-1:0] wrap_up(input logic [IDX_W-1:0] i, input int span);
        return (int'(i) + 1 >= span) ? '0 : IDX_W'(int'(i) + 1);
    endfunction

    // Moving back from zero, or from beyond a lowered capacity, lands on the last entry.
    function automatic logic [IDX_W-1:0] wrap_down(input logic [IDX_W-1:0] i, input int span);
        return (i == '0 || int'(i) > span) ? IDX_W'(span - 1) : i - 1'b1;
    endfunction

    function automatic void store_word(input logic [IDX_W-1:0] i,
                                       input logic signed [DATA_W-1:0] word);
        ring_shadow[i]  = word;
        ring_written[i] = 1'b1;
    endfunction

    // Apply one item to the shadow and return the result the block must give for it.
    function automatic t_out_item next_result(input t_in_item item);
        t_out_item res;
        int        span;
        logic      at_front;
        span       = ring_span();
        res.data   = '0;
        res.status = ST_OK;
        case (item.action)
            ACT_PUSH_REAR, ACT_PUSH_FRONT: begin
                res.data = item.value;
                if (stored >= span) begin
                    res.status = ST_FULL;
                end else begin
                    if (stored == '0) begin
                        front_idx = '0;
                        rear_idx  = '0;
                        store_word('0, item.value);
                    end else if (item.action == ACT_PUSH_REAR) begin
                        rear_idx = wrap_up(rear_idx, span);
                        store_word(rear_idx, item.value);
                    end else begin
                        front_idx = wrap_down(front_idx, span);
                        store_word(front_idx, item.value);
                    end
                    stored = stored + 1'b1;
                end
            end
            ACT_POP_FRONT, ACT_POP_REAR, ACT_PEEK_FRONT, ACT_PEEK_REAR: begin
                at_front = (item.action == ACT_POP_FRONT || item.action == ACT_PEEK_FRONT);
                if (stored == '0) begin
                    res.data   = '1;
                    res.status = ST_EMPTY;
                end else begin
                    res.data = at_front ? ring_shadow[front_idx] : ring_shadow[rear_idx];
                    // A pop of the last entry leaves both indices where they are.
                    if (item.action == ACT_POP_FRONT || item.action == ACT_POP_REAR) begin
                        if (stored > 1) begin
                            if (at_front) begin
                                front_idx = wrap_up(front_idx, span);
                            end else begin
                                rear_idx = wrap_down(rear_idx, span);
                            end
                        end
                        stored = stored - 1'b1;
                    end
                end
            end
            default: begin
                // Undefined actions change nothing and report ok.
            end
        endcase
        res.count = stored;
        return res;
    endfunction

    // Watch the three channels, predict on each accepted item and compare results.
    always @(posedge i_clk) begin
        mismatches = 0;
        if (!i_rst_n) begin
            front_idx = '0;
            rear_idx  = '0;
            stored    = '0;
            cap_reg   = CAP_RESET;
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with no item outstanding: data %0d status %0d count %0d",
                             $time, i_out_item.data, i_out_item.status, i_out_item.count);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_item.data !== want.data) begin
                        $display("%0t: data mismatch: expected %0d, actual %0d",
                                 $time, want.data, i_out_item.data);
                        mismatches++;
                    end
                    if (i_out_item.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, i_out_item.status);
                        mismatches++;
                    end
                    if (i_out_item.count !== want.count) begin
                        $display("%0t: count mismatch: expected %0d, actual %0d",
                                 $time, want.count, i_out_item.count);
                        mismatches++;
                    end
                end
            end
            // An item accepted at this edge still sees the capacity from before it.
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(next_result(i_in_item));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                cap_reg = i_cfg_data;
            end
        end
        o_fail_count <= o_fail_count + mismatches;
        // Tell the stimulus how many results are awaited and whether a read at either end would land on a written word.
        o_pending     <= awaited_results.size();
        o_front_known <= (stored == '0) || ring_written[front_idx];
        o_rear_known  <= (stored == '0) || ring_written[rear_idx];
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for circular_deque_top: clock, reset, item stimulus and the verdict.
// Depends on cdq_pkg, circular_deque_top and cdq_checker, which does all predicting.
module tb_top;
    import cdq_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD  = 300;
    localparam int HOLD_AT    = 150;
    localparam int PHASES     = 10;

    // Action codes the block leaves undefined.
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    t_in_item         in_item;
    logic             out_valid;
    logic             out_stall;
    t_out_item        out_item;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    int               fail_count;
    int               pending;
    logic             front_known;
    logic             rear_known;
    bit               send_quiet;
    bit               recv_quiet;
    int               idle_cycles;

    // Per phase: capacity written, number of items and share of pushes in percent.
    int phase_cap   [PHASES] = '{64, 3, 127, 17, 1, 40, 0, 65, 2, 64};
    int phase_items [PHASES] = '{90, 40, 40, 40, 30, 40, 30, 40, 30, 40};
    int phase_push  [PHASES] = '{90, 30, 50, 55, 50, 60, 50, 40, 50, 20};

    circular_deque_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    cdq_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_item    (out_item),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_front_known (front_known),
        .o_rear_known  (rear_known)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Words biased toward the extremes of the signed range.
    function automatic logic signed [DATA_W-1:0] draw_word();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(DATA_W-1){1'b0}}};
            1: return {1'b0, {(DATA_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] draw_action(input int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
            return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
        end
        if (roll < 97) begin
            case ($urandom_range(0, 3))
                0: return ACT_POP_FRONT;
                1: return ACT_POP_REAR;
                2: return ACT_PEEK_FRONT;
                default: return ACT_PEEK_REAR;
            endcase
        end
        return $urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI;
    endfunction

    // Offer one item after a random gap and return once it has been taken.
    task automatic send_item(input logic [ACT_W-1:0] act, input logic signed [DATA_W-1:0] word);
        int gap;
        if ($urandom_range(0, 19) == 0) begin
            send_quiet = !send_quiet;
        end
        gap = send_quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        // Entries never written are not to be read, so such a read turns into a push.
        if (!front_known && (act == ACT_POP_FRONT || act == ACT_PEEK_FRONT)) begin
            act = ACT_PUSH_REAR;
        end
        if (!rear_known && (act == ACT_POP_REAR || act == ACT_PEEK_REAR)) begin
            act = ACT_PUSH_REAR;
        end
        in_valid <= 1'b1;
        in_item  <= '{action: act, value: word};
        do @(posedge clk); while (in_stall);
    endtask

    // Stop offering and wait until every awaited result has come back.
    task automatic drain();
        @(negedge clk) in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic set_capacity(input logic [CFG_W-1:0] cap);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    // Reset, directed items, then random phases at a range of capacities.
    initial begin : stimulus
        int phase;
        int n;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_stall = 1'b1;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Reads on an empty deque.
        send_item(ACT_PEEK_FRONT, draw_word());
        send_item(ACT_POP_REAR, draw_word());
        send_item(ACT_POP_FRONT, draw_word());
        send_item(ACT_PEEK_REAR, draw_word());
        // Extreme words at both ends; the front push wraps the head below zero.
        send_item(ACT_PUSH_REAR, {1'b0, {(DATA_W-1){1'b1}}});
        send_item(ACT_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
        send_item(ACT_PUSH_REAR, '0);
        send_item(ACT_PUSH_REAR, '1);
        send_item(ACT_PEEK_FRONT, draw_word());
        send_item(ACT_PEEK_REAR, draw_word());
        send_item(ACT_SPARE_LO, draw_word());
        send_item(ACT_SPARE_HI, draw_word());
        send_item(ACT_POP_FRONT, draw_word());
        send_item(ACT_POP_REAR, draw_word());
        send_item(ACT_POP_FRONT, draw_word());
        send_item(ACT_POP_REAR, draw_word());
        send_item(ACT_POP_FRONT, draw_word());
        // A one-entry deque fills on its first push.
        set_capacity(CFG_W'(1));
        send_item(ACT_PUSH_FRONT, draw_word());
        send_item(ACT_PUSH_REAR, draw_word());
        send_item(ACT_PUSH_FRONT, draw_word());
        send_item(ACT_PEEK_REAR, draw_word());
        send_item(ACT_POP_FRONT, draw_word());

        phase_cap[5] = $urandom_range(4, 60);
        for (phase = 0; phase < PHASES; phase++) begin
            set_capacity(CFG_W'(phase_cap[phase]));
            for (n = 0; n < phase_items[phase]; n++) begin
                send_item(draw_action(phase_push[phase]), draw_word());
            end
        end

        drain();
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("circular_deque_top verification clean");
        end else begin
            $display("circular_deque_top verification failed");
        end
        $finish;
    end

    // Result side: random stalls per item, one long hold so the block backs up.
    initial begin : receiver
        int gap;
        int taken;
        taken = 0;
        wait (rst_n);
        forever begin
            if ($urandom_range(0, 19) == 0) begin
                recv_quiet = !recv_quiet;
            end
            gap = recv_quiet ? 0 : $urandom_range(0, 13);
            if (taken == HOLD_AT) begin
                gap = LONG_HOLD;
            end
            repeat (gap) @(negedge clk) out_stall <= 1'b1;
            @(negedge clk) out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid || out_stall);
            taken++;
        end
    end

    // Watchdog: too many cycles without any handshake ends the run.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("circular_deque_top verification failed");
            $finish;
        end
    end

endmodule

// ===== files.f =====
+incdir+src
src/cdq_pkg.sv
src/cdq_ram.sv
src/circular_deque_top.sv
dv/cdq_checker.sv
dv/tb_top.sv
